/* hw/rtl/jsu_pkg.sv */
// Shared types, constants and decode functions for the JSON string unescaper.
// No dependencies; every module of the block imports this package.
package jsu_pkg;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [20:0] CP_REPL = 21'h00FFFD;

    localparam int JOB_MAX    = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_start;
        logic       text_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       out_last;
    } t_out;

    typedef struct packed {
        logic [2:0]       n;
        logic [3:0][7:0]  b;
    } t_enc;

    // results of one input item; all but the last carry ST_DATA
    typedef struct packed {
        logic [2:0]               cnt;
        logic [1:0]               last_st;
        logic [JOB_MAX-1:0][7:0]  b;
    } t_job;

    typedef struct packed {
        logic [7:0] ch;
        logic       ok;
    } t_esc;

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
            return {1'b0, d[3:0]};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            return {1'b0, d[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            return {1'b0, d[3:0]};
        end
        return 5'h10;
    endfunction

    // single-character escapes; 'u' is handled by the caller
    function automatic t_esc esc_map(input logic [7:0] b);
        t_esc e;
        e.ok = 1'b1;
        e.ch = b;
        unique case (b) inside
            8'h62:   e.ch = 8'h08;
            8'h66:   e.ch = 8'h0C;
            8'h6E:   e.ch = 8'h0A;
            8'h72:   e.ch = 8'h0D;
            8'h74:   e.ch = 8'h09;
            8'h22, 8'h5C, 8'h2F: e.ch = b;
            default: begin
                e.ok = 1'b0;
                e.ch = 8'h00;
            end
        endcase
        return e;
    endfunction

    function automatic t_enc utf8_enc(input logic [20:0] cp_in);
        t_enc        e;
        logic [20:0] cp;
        e  = '0;
        cp = cp_in;
        if (cp < 21'h80) begin
            e.n    = 3'd1;
            e.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            e.n    = 3'd2;
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
        end else begin
            if ((cp >= 21'h0D800 && cp <= 21'h0DFFF) || cp > 21'h10FFFF) begin
                cp = CP_REPL;
            end
            if (cp < 21'h10000) begin
                e.n    = 3'd3;
                e.b[0] = {4'b1110, cp[15:12]};
                e.b[1] = {2'b10, cp[11:6]};
                e.b[2] = {2'b10, cp[5:0]};
            end else begin
                e.n    = 3'd4;
                e.b[0] = {5'b11110, cp[20:18]};
                e.b[1] = {2'b10, cp[17:12]};
                e.b[2] = {2'b10, cp[11:6]};
                e.b[3] = {2'b10, cp[5:0]};
            end
        end
        return e;
    endfunction

endpackage

/* hw/rtl/jsu_front.sv */
// Front end: accepts raw string bytes, runs the escape scanner and builds one
// result job per item. Depends on jsu_pkg.
module jsu_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  jsu_pkg::t_in i_data,
    input  logic         i_full,
    output logic         o_push,
    output jsu_pkg::t_job o_job
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_ESCAPE,
        M_HEX,
        M_AFTER_HIGH,
        M_HIGH_BSL,
        M_LOW_HEX,
        M_DONE
    } t_mode;

    t_mode       r_mode, n_mode, e_mode;
    logic [1:0]  r_cnt, n_cnt, e_cnt;
    logic [15:0] r_acc, n_acc, e_acc;
    logic [15:0] r_pend, n_pend, e_pend;
    logic        r_failed, n_failed, e_failed;

    logic        accept;
    logic [7:0]  b;
    logic [4:0]  hv;
    logic [15:0] acc_nx;
    logic        hex_done;
    logic        pfx, do_norm, do_esc, use_cp, use_one;
    logic [20:0] cp;
    logic [7:0]  one_b;
    logic [1:0]  one_st;
    t_enc        enc;
    t_enc        m;
    t_esc        esc;
    t_job        job;

    assign b        = i_data.in_byte;
    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign hv       = hex_val(b);
    assign esc      = esc_map(b);

    always_comb begin
        e_mode   = i_data.string_start ? M_NORMAL : r_mode;
        e_cnt    = i_data.string_start ? 2'd0 : r_cnt;
        e_acc    = i_data.string_start ? 16'h0000 : r_acc;
        e_pend   = i_data.string_start ? 16'h0000 : r_pend;
        e_failed = i_data.string_start ? 1'b0 : r_failed;

        acc_nx   = {e_acc[11:0], hv[3:0]};
        hex_done = (e_cnt == 2'd3);

        n_mode   = e_mode;
        n_cnt    = e_cnt;
        n_acc    = e_acc;
        n_pend   = e_pend;
        n_failed = e_failed;
        pfx      = 1'b0;
        do_norm  = 1'b0;
        do_esc   = 1'b0;
        use_cp   = 1'b0;
        use_one  = 1'b0;
        cp       = 21'h0;
        one_b    = 8'h00;
        one_st   = ST_DATA;

        if (!e_failed) begin
            if (i_data.text_end) begin
                if (e_mode != M_DONE) begin
                    use_one  = 1'b1;
                    one_st   = ST_ERR;
                    n_failed = 1'b1;
                end
            end else begin
                unique case (e_mode) inside
                    M_NORMAL: do_norm = 1'b1;
                    M_ESCAPE: do_esc = 1'b1;
                    M_HEX, M_LOW_HEX: begin
                        if (hv[4]) begin
                            use_one  = 1'b1;
                            one_st   = ST_ERR;
                            n_failed = 1'b1;
                        end else begin
                            n_acc = acc_nx;
                            n_cnt = e_cnt + 2'd1;
                            if (hex_done) begin
                                n_cnt = 2'd0;
                                if (e_mode == M_LOW_HEX
                                    && acc_nx >= 16'hDC00 && acc_nx <= 16'hDFFF) begin
                                    use_cp = 1'b1;
                                    cp     = 21'h10000 + {1'b0, e_pend[9:0], acc_nx[9:0]};
                                    n_mode = M_NORMAL;
                                end else begin
                                    pfx = (e_mode == M_LOW_HEX);
                                    if (acc_nx >= 16'hD800 && acc_nx <= 16'hDBFF) begin
                                        n_pend = acc_nx;
                                        n_mode = M_AFTER_HIGH;
                                    end else begin
                                        use_cp = 1'b1;
                                        cp     = {5'b0, acc_nx};
                                        n_mode = M_NORMAL;
                                    end
                                end
                            end
                        end
                    end
                    M_AFTER_HIGH: begin
                        if (b == CH_BSL) begin
                            n_mode = M_HIGH_BSL;
                        end else begin
                            pfx     = 1'b1;
                            do_norm = 1'b1;
                        end
                    end
                    M_HIGH_BSL: begin
                        if (b == CH_U) begin
                            n_mode = M_LOW_HEX;
                            n_cnt  = 2'd0;
                            n_acc  = 16'h0000;
                        end else begin
                            pfx    = 1'b1;
                            do_esc = 1'b1;
                        end
                    end
                    M_DONE: ;
                    default: ;
                endcase

                if (do_norm) begin
                    n_mode = M_NORMAL;
                    if (b == CH_QUOTE) begin
                        use_one = 1'b1;
                        one_st  = ST_DONE;
                        n_mode  = M_DONE;
                    end else if (b == CH_BSL) begin
                        n_mode = M_ESCAPE;
                    end else if (b < CH_SPACE) begin
                        use_one  = 1'b1;
                        one_st   = ST_ERR;
                        n_failed = 1'b1;
                    end else begin
                        use_one = 1'b1;
                        one_b   = b;
                    end
                end

                if (do_esc) begin
                    if (b == CH_U) begin
                        n_mode = M_HEX;
                        n_cnt  = 2'd0;
                        n_acc  = 16'h0000;
                    end else if (esc.ok) begin
                        use_one = 1'b1;
                        one_b   = esc.ch;
                        n_mode  = M_NORMAL;
                    end else begin
                        use_one  = 1'b1;
                        one_st   = ST_ERR;
                        n_failed = 1'b1;
                    end
                end
            end
        end
    end

    assign enc = utf8_enc(cp);

    always_comb begin
        m = '0;
        if (use_cp) begin
            m = enc;
        end else if (use_one) begin
            m.n    = 3'd1;
            m.b[0] = one_b;
        end

        job         = '0;
        job.last_st = one_st;
        if (pfx) begin
            job.cnt  = 3'd3 + m.n;
            job.b[0] = 8'hEF;
            job.b[1] = 8'hBF;
            job.b[2] = 8'hBD;
            job.b[3] = m.b[0];
            job.b[4] = m.b[1];
            job.b[5] = m.b[2];
        end else begin
            job.cnt  = m.n;
            job.b[0] = m.b[0];
            job.b[1] = m.b[1];
            job.b[2] = m.b[2];
            job.b[3] = m.b[3];
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_NORMAL;
            r_cnt    <= 2'd0;
            r_acc    <= 16'h0000;
            r_pend   <= 16'h0000;
            r_failed <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_pend   <= n_pend;
            r_failed <= n_failed;
        end
    end

endmodule

/* hw/rtl/jsu_fifo.sv */
// Short job queue between the scanner front end and the output back end.
// Depends on jsu_pkg.
module jsu_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    input  logic          i_pop,
    output jsu_pkg::t_job o_head,
    output logic          o_full,
    output logic          o_empty
);
    import jsu_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job queue underflow");
    a_job_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_job.cnt != 3'd0 && i_job.cnt <= 3'(JOB_MAX)))
        else $error("job result count out of range");
`endif

endmodule

/* hw/rtl/jsu_back.sv */
// Back end: walks the head job one result per beat into the output register.
// Depends on jsu_pkg.
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jsu_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output jsu_pkg::t_out o_data
);
    import jsu_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic       r_valid;
    t_out       r_out, n_out;
    logic       load, take, is_last;

    assign load    = !r_valid || i_ready;
    assign take    = load && !i_empty;
    assign is_last = (r_idx == (i_head.cnt - 3'd1));
    assign o_pop   = take && is_last;

    always_comb begin
        n_out.out_byte = i_head.b[r_idx];
        n_out.status   = is_last ? i_head.last_st : ST_DATA;
        n_out.out_last = is_last;
        n_idx          = is_last ? 3'd0 : r_idx + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (take) begin
                r_idx <= n_idx;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != ST_DATA) |-> o_data.out_last)
        else $error("close or error result not last of its item");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_idx < i_head.cnt))
        else $error("result index past job end");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output beat changed while stalled");
`endif

endmodule

/* hw/rtl/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper: front end, job queue and back end.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
// Usage:
//   Input channel i_valid/o_ready carries one beat per raw byte of a string
//   body (after the opening quote), with string_start on the first byte of a
//   new string and text_end to mark the end of the text (no byte carried).
//   Output channel o_valid/i_ready carries decoded UTF-8 bytes (status 0), a
//   string-closed beat (status 1) or an error beat (status 2); out_last marks
//   the last beat caused by one input beat. Inputs that cause nothing (an
//   opening backslash, the leading hex digits of a \u escape, bytes after the
//   close or after an error) produce no output beat.
//   The first result of a beat passes through the job queue memory and then
//   the back end output register. Throughput: one input beat per cycle while
//   each beat yields at most one result and the queue is not full; the back
//   end sends one result per cycle while i_ready is high (up to 6 per beat).
//   A four-entry job queue decouples the sides: o_ready drops only when the
//   queue is full, so a stalled receiver backs up the input after four jobs.
//   Reset (synchronous, active low) empties the queue and puts the scanner in
//   normal text mode with no held surrogate and no error.
module json_string_unescape_utf8 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  jsu_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output jsu_pkg::t_out o_data
);
    import jsu_pkg::*;

    logic full, empty, push, pop;
    t_job job, head;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job)
    );

    jsu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

/* dv/json_string_unescape_utf8_check.sv */
`timescale 1ns / 1ps
// Scoreboard for the JSON string unescaper: predicts the result beats of every
// accepted input beat and compares each output beat against the oldest one.
// Depends on jsu_pkg for the beat types, status codes and character constants.
module json_string_unescape_utf8_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  jsu_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  jsu_pkg::t_out i_out_data,
    output int            o_err_count,
    output int            o_outstanding
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_ESC,
        SCAN_HEX,
        SCAN_HIGH,
        SCAN_HIGH_BSL,
        SCAN_LOW_HEX,
        SCAN_CLOSED
    } t_scan;

    t_scan       scan_q;
    logic [2:0]  nib_cnt;
    logic [15:0] unit_acc;
    logic [15:0] high_unit;
    logic        dead;
    t_out        step_beats[$];
    t_out        expected_beats[$];
    int          mismatches = 0;

    task automatic clear_scan();
        scan_q    = SCAN_TEXT;
        nib_cnt   = 3'd0;
        unit_acc  = 16'h0000;
        high_unit = 16'h0000;
        dead      = 1'b0;
    endtask

    task automatic put_beat(input logic [7:0] b, input logic [1:0] st);
        t_out r;
        r.out_byte = b;
        r.status   = st;
        r.out_last = 1'b0;
        if (step_beats.size() < JOB_MAX) begin
            step_beats.insert(step_beats.size(), r);
        end
    endtask

    task automatic raise_error();
        put_beat(8'h00, ST_ERR);
        dead = 1'b1;
    endtask

    task automatic put_cp(input logic [20:0] cp_in);
        logic [20:0] cp;
        cp = cp_in;
        if (cp < 21'h80) begin
            put_beat(cp[7:0], ST_DATA);
        end else if (cp < 21'h800) begin
            put_beat({3'b110, cp[10:6]}, ST_DATA);
            put_beat({2'b10, cp[5:0]}, ST_DATA);
        end else begin
            if ((cp >= 21'h0D800 && cp <= 21'h0DFFF) || cp > 21'h10FFFF) begin
                cp = CP_REPL;
            end
            if (cp < 21'h10000) begin
                put_beat({4'b1110, cp[15:12]}, ST_DATA);
            end else begin
                put_beat({5'b11110, cp[20:18]}, ST_DATA);
                put_beat({2'b10, cp[17:12]}, ST_DATA);
            end
            put_beat({2'b10, cp[11:6]}, ST_DATA);
            put_beat({2'b10, cp[5:0]}, ST_DATA);
        end
    endtask

    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        logic [7:0] d;
        d = 8'hFF;
        if (b >= "0" && b <= "9") begin
            d = b - 8'h30;
        end else if (b >= "A" && b <= "F") begin
            d = b - 8'h37;
        end else if (b >= "a" && b <= "f") begin
            d = b - 8'h57;
        end
        return (d > 8'd15) ? 5'h10 : {1'b0, d[3:0]};
    endfunction

    task automatic take_nibble(input logic [7:0] b, output logic full);
        logic [4:0] d;
        d    = nibble_of(b);
        full = 1'b0;
        if (d[4]) begin
            raise_error();
        end else begin
            unit_acc = {unit_acc[11:0], d[3:0]};
            nib_cnt  = nib_cnt + 3'd1;
            if (nib_cnt >= 3'd4) begin
                nib_cnt = 3'd0;
                full    = 1'b1;
            end
        end
    endtask

    task automatic take_unit(input logic [15:0] v);
        if (v >= 16'hD800 && v <= 16'hDBFF) begin
            high_unit = v;
            scan_q    = SCAN_HIGH;
        end else begin
            put_cp({5'b0, v});
            scan_q = SCAN_TEXT;
        end
    endtask

    task automatic text_byte(input logic [7:0] b);
        if (b == CH_QUOTE) begin
            put_beat(8'h00, ST_DONE);
            scan_q = SCAN_CLOSED;
        end else if (b == CH_BSL) begin
            scan_q = SCAN_ESC;
        end else if (b < CH_SPACE) begin
            raise_error();
        end else begin
            put_beat(b, ST_DATA);
        end
    endtask

    task automatic escape_byte(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        case (b) inside
            "b": c = 8'h08;
            "f": c = 8'h0C;
            "n": c = 8'h0A;
            "r": c = 8'h0D;
            "t": c = 8'h09;
            CH_QUOTE, CH_BSL, "/": c = b;
            CH_U: begin
                scan_q   = SCAN_HEX;
                nib_cnt  = 3'd0;
                unit_acc = 16'h0000;
                return;
            end
            default: begin
                raise_error();
                return;
            end
        endcase
        put_beat(c, ST_DATA);
        scan_q = SCAN_TEXT;
    endtask

    task automatic predict(input t_in it);
        logic [7:0]  b;
        logic        full;
        logic [20:0] pair_cp;
        t_out        r;
        b = it.in_byte;
        step_beats.delete();
        if (it.string_start) begin
            clear_scan();
        end
        if (!dead) begin
            if (it.text_end) begin
                if (scan_q != SCAN_CLOSED) begin
                    raise_error();
                end
            end else begin
                case (scan_q)
                    SCAN_TEXT: text_byte(b);
                    SCAN_ESC:  escape_byte(b);
                    SCAN_HEX: begin
                        take_nibble(b, full);
                        if (full) begin
                            take_unit(unit_acc);
                        end
                    end
                    SCAN_HIGH: begin
                        if (b == CH_BSL) begin
                            scan_q = SCAN_HIGH_BSL;
                        end else begin
                            put_cp(CP_REPL);
                            scan_q = SCAN_TEXT;
                            text_byte(b);
                        end
                    end
                    SCAN_HIGH_BSL: begin
                        if (b == CH_U) begin
                            scan_q   = SCAN_LOW_HEX;
                            nib_cnt  = 3'd0;
                            unit_acc = 16'h0000;
                        end else begin
                            put_cp(CP_REPL);
                            scan_q = SCAN_TEXT;
                            escape_byte(b);
                        end
                    end
                    SCAN_LOW_HEX: begin
                        take_nibble(b, full);
                        if (full) begin
                            if (unit_acc >= 16'hDC00 && unit_acc <= 16'hDFFF) begin
                                pair_cp = 21'h10000 + {1'b0, high_unit[9:0], unit_acc[9:0]};
                                put_cp(pair_cp);
                                scan_q = SCAN_TEXT;
                            end else begin
                                put_cp(CP_REPL);
                                take_unit(unit_acc);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        foreach (step_beats[i]) begin
            r          = step_beats[i];
            r.out_last = (i == step_beats.size() - 1);
            expected_beats.insert(expected_beats.size(), r);
        end
    endtask

    task automatic check_beat(input t_out got);
        t_out want;
        if (expected_beats.size() == 0) begin
            $error("unexpected beat: out_byte %h status %0d out_last %0d",
                   got.out_byte, got.status, got.out_last);
            mismatches++;
            return;
        end
        want = expected_beats.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            mismatches++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
        if (got.out_last !== want.out_last) begin
            $error("out_last: expected %0d, got %0d", want.out_last, got.out_last);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_beat(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                predict(i_in_data);
            end
        end
        o_err_count   <= mismatches;
        o_outstanding <= expected_beats.size();
    end

endmodule

/* dv/tb_json_string_unescape_utf8.sv */
`timescale 1ns / 1ps
// Top of the JSON string unescaper testbench: clock, reset, byte stimulus,
// output back-pressure and verdict. Depends on jsu_pkg, the block and
// json_string_unescape_utf8_check, which does all prediction and comparison.
module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam int ITEM_TARGET    = 220;
    localparam int PAUSE_EVERY    = 70;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data  = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;
    int   err_count;
    int   outstanding;

    int   items_sent = 0;
    int   burst_left = 0;
    int   next_pause = PAUSE_EVERY;
    t_in  str_q[$];

    int   rx_mode   = 0;
    int   rx_left   = 0;
    int   rx_tick   = 0;
    int   rx_period = 2;

    always #2 i_clk = ~i_clk;

    json_string_unescape_utf8 i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    json_string_unescape_utf8_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_data    (o_data),
        .o_err_count   (err_count),
        .o_outstanding (outstanding)
    );

    // receiver: switch between always ready, mostly ready, mostly stalled, periodic
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            rx_left   = $urandom_range(32, 96);
            rx_period = $urandom_range(2, 12);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 3) != 0);
            2:       i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= (rx_tick % rx_period == 0);
        endcase
    end

    function automatic t_in mk(input logic [7:0] b, input logic st, input logic te);
        t_in d;
        d.in_byte      = b;
        d.string_start = st;
        d.text_end     = te;
        return d;
    endfunction

    task automatic sender_pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                    : $urandom_range(0, 10);
        end
    endtask

    task automatic send_beat(input t_in d);
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        sender_pace();
    endtask

    // hold off until every predicted beat has drained
    task automatic drain_pause();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return 8'h30 + n;
        end
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") ||
                   (b >= "a" && b <= "f"));
        return b;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        case ($urandom_range(0, 15))
            0: b = CH_SPACE;
            1: b = 8'hFF;
            default: begin
                do begin
                    b = 8'($urandom_range(32, 255));
                end while (b == CH_QUOTE || b == CH_BSL);
            end
        endcase
        return b;
    endfunction

    function automatic logic [7:0] esc_char();
        case ($urandom_range(0, 7))
            0:       return "b";
            1:       return "f";
            2:       return "n";
            3:       return "r";
            4:       return "t";
            5:       return CH_QUOTE;
            6:       return CH_BSL;
            default: return "/";
        endcase
    endfunction

    function automatic logic [7:0] bad_esc();
        logic [7:0] b;
        do begin
            b = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? "v" : "x")
                                            : 8'($urandom_range(0, 255));
        end while (b == "b" || b == "f" || b == "n" || b == "r" || b == "t" ||
                   b == CH_QUOTE || b == CH_BSL || b == "/" || b == CH_U);
        return b;
    endfunction

    // 0: ASCII, 1: two-byte, 2: three-byte, 3: high surrogate, 4: low surrogate
    function automatic logic [15:0] rand_unit(input int cls);
        logic [15:0] lo;
        logic [15:0] hi;
        case (cls)
            0: begin
                lo = 16'h0000;
                hi = 16'h007F;
            end
            1: begin
                lo = 16'h0080;
                hi = 16'h07FF;
            end
            2: begin
                if ($urandom_range(0, 1)) begin
                    lo = 16'h0800;
                    hi = 16'hD7FF;
                end else begin
                    lo = 16'hE000;
                    hi = 16'hFFFF;
                end
            end
            3: begin
                lo = 16'hD800;
                hi = 16'hDBFF;
            end
            default: begin
                lo = 16'hDC00;
                hi = 16'hDFFF;
            end
        endcase
        case ($urandom_range(0, 9))
            0:       return lo;
            1:       return hi;
            default: return 16'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic push_raw(input logic [7:0] b, input logic te);
        str_q.insert(str_q.size(), mk(b, 1'b0, te));
    endtask

    task automatic push_hex_unit(input logic [15:0] v);
        push_raw(CH_BSL, 1'b0);
        push_raw(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--) begin
            push_raw(hex_char(v[i*4 +: 4]), 1'b0);
        end
    endtask

    task automatic push_bad_hex();
        push_raw(CH_BSL, 1'b0);
        push_raw(CH_U, 1'b0);
        repeat ($urandom_range(0, 3)) push_raw(hex_char(4'($urandom_range(0, 15))), 1'b0);
        push_raw(non_hex(), 1'b0);
    endtask

    task automatic add_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            push_raw(plain_char(), 1'b0);
        end else if (r < 45) begin
            push_raw(CH_BSL, 1'b0);
            push_raw(esc_char(), 1'b0);
        end else if (r < 65) begin
            push_hex_unit(rand_unit($urandom_range(0, 4)));
        end else if (r < 80) begin
            push_hex_unit(rand_unit(3));
            push_hex_unit(rand_unit(4));
        end else if (r < 84) begin
            push_hex_unit(rand_unit(3));
            push_raw(plain_char(), 1'b0);
        end else if (r < 88) begin
            push_hex_unit(rand_unit(3));
            push_raw(CH_BSL, 1'b0);
            push_raw(esc_char(), 1'b0);
        end else if (r < 91) begin
            push_hex_unit(rand_unit(3));
            push_hex_unit(rand_unit($urandom_range(0, 3)));
        end else if (r < 93) begin
            push_hex_unit(rand_unit(3));
            push_raw(CH_BSL, 1'b0);
            push_raw(bad_esc(), 1'b0);
        end else if (r < 95) begin
            push_raw(8'($urandom_range(0, 31)), 1'b0);
        end else if (r < 97) begin
            push_raw(CH_BSL, 1'b0);
            push_raw(bad_esc(), 1'b0);
        end else if (r < 99) begin
            push_bad_hex();
        end else begin
            push_hex_unit(rand_unit(3));
            push_bad_hex();
        end
    endtask

    task automatic run_string();
        int  r;
        t_in d;
        str_q.delete();
        if ($urandom_range(0, 9) != 0) begin
            repeat ($urandom_range(1, 6)) add_token();
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            push_raw(CH_QUOTE, 1'b0);
        end else if (r < 85) begin
            push_raw(8'($urandom_range(0, 255)), 1'b1);
        end else if (str_q.size() == 0) begin
            push_raw(plain_char(), 1'b0);
        end
        if (r < 75 && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                push_raw(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        d              = str_q[0];
        d.string_start = 1'b1;
        str_q[0]       = d;
        foreach (str_q[i]) send_beat(str_q[i]);
    endtask

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("tb_json_string_unescape_utf8: done, errors");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // decoded straight after reset, no start needed
        send_beat(mk("a", 1'b0, 1'b0));
        send_beat(mk(8'hFF, 1'b0, 1'b0));
        send_beat(mk(CH_BSL, 1'b0, 1'b0));
        send_beat(mk("n", 1'b0, 1'b0));
        // surrogate pair to a four-byte sequence
        send_beat(mk(CH_BSL, 1'b0, 1'b0));
        send_beat(mk(CH_U, 1'b0, 1'b0));
        send_beat(mk("D", 1'b0, 1'b0));
        send_beat(mk("8", 1'b0, 1'b0));
        send_beat(mk("3", 1'b0, 1'b0));
        send_beat(mk("d", 1'b0, 1'b0));
        send_beat(mk(CH_BSL, 1'b0, 1'b0));
        send_beat(mk(CH_U, 1'b0, 1'b0));
        send_beat(mk("D", 1'b0, 1'b0));
        send_beat(mk("E", 1'b0, 1'b0));
        send_beat(mk("0", 1'b0, 1'b0));
        send_beat(mk("0", 1'b0, 1'b0));
        send_beat(mk(CH_QUOTE, 1'b0, 1'b0));
        // ignored after the close
        send_beat(mk("x", 1'b0, 1'b0));
        send_beat(mk(8'h00, 1'b0, 1'b1));
        // start with end, raw control byte, ignored while failed, bad escape
        send_beat(mk(8'hFF, 1'b1, 1'b1));
        send_beat(mk(8'h00, 1'b1, 1'b0));
        send_beat(mk("A", 1'b0, 1'b0));
        send_beat(mk(CH_BSL, 1'b1, 1'b0));
        send_beat(mk("v", 1'b0, 1'b0));
        drain_pause();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_beat(mk(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1))));
                end
            end else begin
                run_string();
            end
            if (items_sent >= next_pause) begin
                drain_pause();
                next_pause += PAUSE_EVERY;
            end
        end

        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && outstanding == 0) begin
            $display("tb_json_string_unescape_utf8: done, clean");
        end else begin
            $display("tb_json_string_unescape_utf8: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_fifo.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape_utf8.sv
dv/json_string_unescape_utf8_check.sv
dv/tb_json_string_unescape_utf8.sv
